@@ rtl/iabst_pkg.sv @@
// ----------------------------------------------------------------------------
// iabst_pkg
// Shared types and constants for the implicit-array binary search tree block.
// ----------------------------------------------------------------------------
package iabst_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4
  } status_t;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
  } out_t;

  // One tree slot as held in the node memory.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } node_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_WALK,
    CS_HOLD
  } ctrl_state_t;

endpackage

@@ rtl/iabst_mem.sv @@
// ----------------------------------------------------------------------------
// iabst_mem
// Node memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iabst_mem #(
  parameter int TREE_LEVELS = 5
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [TREE_LEVELS-1:0] wr_addr,
  input  iabst_pkg::node_t       wr_data,
  input  logic                   rd_en,
  input  logic [TREE_LEVELS-1:0] rd_addr,
  output iabst_pkg::node_t       rd_data
);
  import iabst_pkg::*;

  localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;

  node_t mem [NODE_COUNT];
  node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/iabst_ctrl.sv @@
// ----------------------------------------------------------------------------
// iabst_ctrl
// Walk sequencer: clears the node memory after reset, then steps one tree
// level per cycle for each command and produces its result.
// ----------------------------------------------------------------------------
module iabst_ctrl #(
  parameter int TREE_LEVELS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  iabst_pkg::in_t         in_item,
  output logic                   mem_wr_en,
  output logic [TREE_LEVELS-1:0] mem_wr_addr,
  output iabst_pkg::node_t       mem_wr_data,
  output logic                   mem_rd_en,
  output logic [TREE_LEVELS-1:0] mem_rd_addr,
  input  iabst_pkg::node_t       mem_rd_data,
  input  logic                   res_free,
  output logic                   res_valid,
  output iabst_pkg::out_t        res_item
);
  import iabst_pkg::*;

  localparam int AW = TREE_LEVELS;
  localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;
  localparam logic [AW:0]   NODE_COUNT_W = (AW+1)'(NODE_COUNT);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(NODE_COUNT - 1);

  ctrl_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  in_t           cmd_r, cmd_nxt;
  out_t          hold_r, hold_nxt;

  logic          accept;
  logic          hit;
  logic          go_left;
  logic [AW:0]   child_idx;
  logic          past_end;
  logic          finish;
  out_t          walk_res;
  logic          walk_write;

  assign accept = (state_r == CS_IDLE) && in_valid;

  // Compare the key of the slot read in the previous cycle, choose the child to visit and form the result.
  always_comb begin
    hit       = mem_rd_data.valid && (mem_rd_data.key == cmd_r.key);
    go_left   = cmd_r.key < mem_rd_data.key;
    child_idx = {idx_r, 1'b0} + (go_left ? (AW+1)'(1) : (AW+1)'(2));
    past_end  = child_idx >= NODE_COUNT_W;
    finish    = !mem_rd_data.valid || hit || past_end;

    walk_write = 1'b0;
    if (!mem_rd_data.valid) begin
      if (cmd_r.cmd == CMD_SEARCH) begin
        walk_res.status = ST_MISS;
        walk_res.slot   = '0;
      end else begin
        walk_res.status = ST_INSERTED;
        walk_res.slot   = SLOT_W'(idx_r);
        walk_write      = 1'b1;
      end
    end else if (hit) begin
      walk_res.status = (cmd_r.cmd == CMD_SEARCH) ? ST_HIT : ST_DUPLICATE;
      walk_res.slot   = SLOT_W'(idx_r);
    end else begin
      walk_res.status = (cmd_r.cmd == CMD_SEARCH) ? ST_MISS : ST_FULL;
      walk_res.slot   = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_IDLE: begin
        if (accept) begin
          state_nxt = CS_WALK;
        end
      end
      CS_WALK: begin
        if (finish) begin
          state_nxt = res_free ? CS_IDLE : CS_HOLD;
        end
      end
      CS_HOLD: begin
        if (res_free) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_CLEAR;
    endcase
  end

  // Outputs and datapath register updates.
  always_comb begin
    in_ready     = 1'b0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = idx_r;
    mem_wr_data  = '{valid: 1'b1, key: cmd_r.key};
    mem_rd_en    = 1'b0;
    mem_rd_addr  = '0;
    res_valid    = 1'b0;
    res_item     = walk_res;
    idx_nxt      = idx_r;
    clr_addr_nxt = clr_addr_r;
    cmd_nxt      = cmd_r;
    hold_nxt     = hold_r;
    case (state_r)
      CS_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mem_rd_en = 1'b1;
          idx_nxt   = '0;
          cmd_nxt   = in_item;
        end
      end
      CS_WALK: begin
        if (finish) begin
          // The insert lands here; the next read cannot come before the
          // following cycle, so no forwarding is needed.
          mem_wr_en = walk_write;
          res_valid = res_free;
          hold_nxt  = walk_res;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = child_idx[AW-1:0];
          idx_nxt     = child_idx[AW-1:0];
        end
      end
      CS_HOLD: begin
        res_valid = res_free;
        res_item  = hold_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CS_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cmd_r  <= cmd_nxt;
    hold_r <= hold_nxt;
  end

endmodule

@@ rtl/implicit_array_bst_insert_search.sv @@
// ----------------------------------------------------------------------------
// implicit_array_bst_insert_search
// Binary search tree held in an implicit array (children of slot i at 2i+1
// and 2i+2), with insert and search commands.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_item  (cmd, key)
//   out_     output     out_valid / out_ready  out_item (status, slot)
//
// A command is taken and then walks at most TREE_LEVELS tree levels (5 by
// default), one level a cycle; the single-port read of the node memory
// sets this rate.
// After reset all 2^TREE_LEVELS - 1 slots (31 by default) of the node memory
// are cleared, one slot a cycle, with in_ready held low.
// A result waiting in the output register does not stop the next transaction
// from being taken; the walk only holds at its end if the register is full.
// ----------------------------------------------------------------------------
module implicit_array_bst_insert_search #(
  parameter int TREE_LEVELS = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  iabst_pkg::in_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output iabst_pkg::out_t out_item
);
  import iabst_pkg::*;

  logic                   mem_wr_en;
  logic [TREE_LEVELS-1:0] mem_wr_addr;
  node_t                  mem_wr_data;
  logic                   mem_rd_en;
  logic [TREE_LEVELS-1:0] mem_rd_addr;
  node_t                  mem_rd_data;

  logic res_free;
  logic res_valid;
  out_t res_item;

  logic out_valid_r, out_valid_nxt;
  out_t out_item_r, out_item_nxt;

  iabst_ctrl #(
    .TREE_LEVELS(TREE_LEVELS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_free    (res_free),
    .res_valid   (res_valid),
    .res_item    (res_item)
  );

  iabst_mem #(
    .TREE_LEVELS(TREE_LEVELS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The output register is free when empty or being emptied this cycle.
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the implicit-array binary search tree. A behavioural
// copy of the tree predicts the status and slot of every command. Directed
// tests cover the empty tree, duplicates, the extreme keys and walks that run
// off the last level. A long random mix of inserts and searches follows, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import iabst_pkg::*;

  localparam int TREE_LEVELS = 5;
  localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
  localparam int RANDOM_CMDS = 1950;
  localparam int QUIET_CMDS  = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 2 * (TREE_LEVELS + 1) + 4;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_t out_item;

  // Behavioural copy of the tree.
  logic signed [KEY_W-1:0] tree_key  [NODE_COUNT];
  logic                    tree_used [NODE_COUNT];

  out_t pending_results[$];
  int   fault_count = 0;
  int   cycle_count = 0;
  int   stall_left  = 0;
  bit   idle_en     = 1'b1;

  implicit_array_bst_insert_search #(
    .TREE_LEVELS(TREE_LEVELS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Walks the tree for one command and applies an insert to the local copy.
  function automatic out_t walk_tree(in_t item);
    out_t res;
    int   idx;
    idx = 0;
    res = '0;
    forever begin
      if (idx >= NODE_COUNT) begin
        res.status = (item.cmd == CMD_SEARCH) ? ST_MISS : ST_FULL;
        res.slot   = '0;
        return res;
      end
      if (!tree_used[idx]) begin
        if (item.cmd == CMD_SEARCH) begin
          res.status = ST_MISS;
          res.slot   = '0;
        end else begin
          tree_key[idx]  = item.key;
          tree_used[idx] = 1'b1;
          res.status     = ST_INSERTED;
          res.slot       = idx[SLOT_W-1:0];
        end
        return res;
      end
      if (item.key == tree_key[idx]) begin
        res.status = (item.cmd == CMD_SEARCH) ? ST_HIT : ST_DUPLICATE;
        res.slot   = idx[SLOT_W-1:0];
        return res;
      end
      idx = (item.key < tree_key[idx]) ? 2 * idx + 1 : 2 * idx + 2;
    end
  endfunction

  // A key already held in the tree, or a random one while the tree is empty.
  function automatic logic signed [KEY_W-1:0] stored_key();
    int used;
    int pick;
    used = 0;
    foreach (tree_used[i]) if (tree_used[i]) used++;
    if (used == 0) return $urandom;
    pick = $urandom_range(0, used - 1);
    foreach (tree_used[i]) begin
      if (tree_used[i]) begin
        if (pick == 0) return tree_key[i];
        pick--;
      end
    end
    return '0;
  endfunction

  task automatic note_fault(string what, out_t want, out_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("MISMATCH %s: expected status %0d slot %0d, got status %0d slot %0d",
               what, want.status, want.slot, got.status, got.slot);
  endtask

  // Sends one command and records its expected result once it is accepted.
  task automatic send_cmd(logic cmd, logic signed [KEY_W-1:0] key);
    in_t item;
    item.cmd = cmd;
    item.key = key;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(walk_tree(item));
  endtask

  // Result side: random stall bursts on out_ready.
  always @(posedge clk) begin
    if (!rst_n || !idle_en) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_fault("unexpected transaction", '0, out_item);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status != want.status) note_fault("status", want, out_item);
        else if (out_item.slot != want.slot) note_fault("slot", want, out_item);
      end
    end
  end

  task automatic test_empty_tree();
    send_cmd(CMD_SEARCH, 32'sd0);
    send_cmd(CMD_SEARCH, KEY_MIN);
    send_cmd(CMD_SEARCH, -32'sd1);
  endtask

  // Root 0, then -1 to the left, so an all-ones key must be storable.
  task automatic test_first_inserts();
    send_cmd(CMD_INSERT, 32'sd0);
    send_cmd(CMD_INSERT, -32'sd1);
    send_cmd(CMD_INSERT, 32'sd100);
    send_cmd(CMD_INSERT, KEY_MIN);
    send_cmd(CMD_INSERT, KEY_MAX);
    send_cmd(CMD_INSERT, 32'sd0);
    send_cmd(CMD_INSERT, KEY_MIN);
    send_cmd(CMD_INSERT, -32'sd1);
  endtask

  task automatic test_searches();
    send_cmd(CMD_SEARCH, 32'sd0);
    send_cmd(CMD_SEARCH, -32'sd1);
    send_cmd(CMD_SEARCH, KEY_MIN);
    send_cmd(CMD_SEARCH, KEY_MAX);
    send_cmd(CMD_SEARCH, 32'sd50);
    send_cmd(CMD_SEARCH, -32'sd2);
  endtask

  // An ascending run builds a chain that leaves the array below the last level.
  task automatic test_path_overflow();
    send_cmd(CMD_INSERT, 32'sd1);
    send_cmd(CMD_INSERT, 32'sd2);
    send_cmd(CMD_INSERT, 32'sd3);
    send_cmd(CMD_INSERT, 32'sd4);
    send_cmd(CMD_SEARCH, 32'sd4);
    send_cmd(CMD_INSERT, 32'sd4);
    send_cmd(CMD_SEARCH, 32'sd3);
  endtask

  task automatic test_random_mix();
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n >= RANDOM_CMDS - QUIET_CMDS) idle_en = 1'b0;
      else if (n % 150 == 0) idle_en = ($urandom_range(0, 3) != 0);
      cmd = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1, 2: key = $urandom;
        3:       key = $signed($urandom_range(0, 64)) - 32'sd32;
        4:       key = $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 3)
                                            : KEY_MAX - $urandom_range(0, 3);
        5, 6, 7: key = stored_key();
        default: key = stored_key() + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
      endcase
      send_cmd(cmd, key);
    end
  endtask

  initial begin
    foreach (tree_used[i]) begin
      tree_used[i] = 1'b0;
      tree_key[i]  = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tree();
    test_first_inserts();
    test_searches();
    test_path_overflow();
    test_random_mix();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
